[sv/pdd_pkg.sv]
// Shared types and constants for the pixel desaturate/darken core.
// Used by the channel interfaces, the core and its checker; no dependencies.
package pdd_pkg;

  typedef logic [7:0]  chan_t;     // one color channel byte
  typedef logic [10:0] q10_t;      // Q10 factor, 1024 = 1.0
  typedef logic [0:0]  reg_idx_t;  // configuration register index
  typedef logic [23:0] luma_t;     // Q16 luma, at most 255 * 65536
  typedef logic [33:0] blend_t;    // Q26 blended channel
  typedef logic [44:0] prod_t;     // Q36 scaled channel

  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned FRAC_OUT = 36;   // fraction bits of prod_t

  localparam reg_idx_t REG_SATURATION = 1'b0;
  localparam reg_idx_t REG_BRIGHTNESS = 1'b1;

  localparam q10_t  Q10_ONE  = 11'd1024;
  localparam luma_t W_RED    = 24'd19595;
  localparam luma_t W_GREEN  = 24'd38470;
  localparam luma_t W_BLUE   = 24'd7471;
  localparam chan_t CHAN_MAX = 8'd255;

  // Values above 1.0 saturate to 1.0.
  function automatic q10_t clamp_q10(input q10_t v);
    clamp_q10 = (v > Q10_ONE) ? Q10_ONE : v;
  endfunction

endpackage

[sv/pdd_ifs.sv]
// Valid/ready channel interfaces for pixel requests into and out of the core.
// Depends on pdd_pkg for the channel type.
interface pdd_in_if;
  import pdd_pkg::*;
  logic  valid;
  logic  ready;
  chan_t blue_in;
  chan_t green_in;
  chan_t red_in;
  modport source (output valid, output blue_in, output green_in, output red_in,
                  input ready);
  modport sink (input valid, input blue_in, input green_in, input red_in,
                output ready);
endinterface

interface pdd_out_if;
  import pdd_pkg::*;
  logic  valid;
  logic  ready;
  chan_t blue_out;
  chan_t green_out;
  chan_t red_out;
  modport source (output valid, output blue_out, output green_out, output red_out,
                  input ready);
  modport sink (input valid, input blue_out, input green_out, input red_out,
                output ready);
endinterface

[sv/pixel_desaturate_darken_core.sv]
// Pixel desaturate and darken: luma mix by saturation, then scale by brightness.
// Depends on pdd_pkg and the channel interfaces in pdd_ifs.sv.
// Four register stages (luma, blend, scale, output), each with its own valid bit,
// so bubbles fill while the output stalls. Throughput: one pixel per cycle
// while the output does not stall.
// Reset (rst, synchronous): empties the pipeline, saturation and brightness to 1024.
module pixel_desaturate_darken_core (
  input  logic                clk,
  input  logic                rst,
  pdd_in_if.sink              pix_in,
  pdd_out_if.source           pix_out,
  input  logic                wr_en,
  input  pdd_pkg::reg_idx_t   wr_index,
  input  pdd_pkg::q10_t       wr_data
);
  import pdd_pkg::*;

  q10_t  saturation;
  q10_t  brightness;
  q10_t  sat_c;
  q10_t  inv_sat;
  q10_t  bri_c;

  logic  v1, v2, v3, vo;
  logic  r1, r2, r3, ro;

  chan_t  chan1 [NUM_CHAN];
  luma_t  luma1;
  luma_t  luma_next;
  blend_t blend2 [NUM_CHAN];
  prod_t  prod3 [NUM_CHAN];
  chan_t  res_next [NUM_CHAN];
  chan_t  res [NUM_CHAN];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= Q10_ONE;
      brightness <= Q10_ONE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SATURATION: saturation <= wr_data;
        REG_BRIGHTNESS: brightness <= wr_data;
        default: ;
      endcase
    end
  end

  assign sat_c   = clamp_q10(saturation);
  assign inv_sat = Q10_ONE - sat_c;
  assign bri_c   = clamp_q10(brightness);

  // A stage advances when it is empty or the next one advances.
  assign ro = !vo || pix_out.ready;
  assign r3 = !v3 || ro;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign pix_in.ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (r1) v1 <= pix_in.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) vo <= v3;
    end
  end

  // Stage 1: luma
  assign luma_next = luma_t'(pix_in.red_in)   * W_RED
                   + luma_t'(pix_in.green_in) * W_GREEN
                   + luma_t'(pix_in.blue_in)  * W_BLUE;

  always_ff @(posedge clk) begin
    if (r1 && pix_in.valid) begin
      luma1    <= luma_next;
      chan1[0] <= pix_in.blue_in;
      chan1[1] <= pix_in.green_in;
      chan1[2] <= pix_in.red_in;
    end
  end

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
    logic [18:0] cs;
    logic [8:0]  whole;

    // Stage 2: luma*(1-s) + chan*s in Q26
    assign cs = 19'(chan1[i]) * 19'(sat_c);

    always_ff @(posedge clk) begin
      if (r2 && v1) begin
        blend2[i] <= blend_t'(luma1) * blend_t'(inv_sat) + (blend_t'(cs) << 16);
      end
    end

    // Stage 3: scale by brightness
    always_ff @(posedge clk) begin
      if (r3 && v2) begin
        prod3[i] <= prod_t'(blend2[i]) * prod_t'(bri_c);
      end
    end

    // Drop the fraction and clamp into the output register
    assign whole       = prod3[i][FRAC_OUT +: 9];
    assign res_next[i] = (whole > 9'(CHAN_MAX)) ? CHAN_MAX : whole[7:0];

    always_ff @(posedge clk) begin
      if (ro && v3) begin
        res[i] <= res_next[i];
      end
    end
  end

  assign pix_out.valid     = vo;
  assign pix_out.blue_out  = res[0];
  assign pix_out.green_out = res[1];
  assign pix_out.red_out   = res[2];

endmodule

[sv/pdd_checker.sv]
// Port-level checks for pixel_desaturate_darken_core, attached by bind.
// Depends on pdd_pkg for the channel type.
module pdd_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pdd_pkg::chan_t out_blue,
  input pdd_pkg::chan_t out_green,
  input pdd_pkg::chan_t out_red
);
  import pdd_pkg::*;

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Right after reset, out_valid stays low while a first request fills the luma, blend and scale stages.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("output appeared too early after reset");

  // Input backpressure only when the output is held.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_blue)
      && $stable(out_green) && $stable(out_red))
    else $error("stalled result changed");

endmodule

bind pixel_desaturate_darken_core pdd_checker u_pdd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_blue  (pix_out.blue_out),
  .out_green (pix_out.green_out),
  .out_red   (pix_out.red_out)
);

[dv/testbench.sv]
// Self-checking bench for pixel_desaturate_darken_core: typed and predicted pixels
// through valid/ready channels, with random stalls on both sides.
// Depends on pdd_pkg and the channel interfaces in pdd_ifs.sv.
`timescale 1ns / 1ps

module testbench;
  import pdd_pkg::*;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    q10_t   sat;
    q10_t   bri;
    pixel_t px;
    logic   known;
    pixel_t typed;
  } dir_row_t;

  localparam int N_DIRECTED    = 23;
  localparam int N_PHASES      = 10;
  localparam int PHASE_ITEMS   = 135;
  localparam int SQUEEZE_PHASE = 4;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_LINES     = 40;

  // Rows with known set carry the result read straight off the arithmetic:
  // full factors pass the pixel through, zero saturation gives luma grey,
  // zero brightness gives black, factors above one act as one.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{11'd1024, 11'd1024, '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1024, 11'd1024, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{11'd1024, 11'd1024, '{8'd255, 8'd0,   8'd0  }, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{11'd1024, 11'd1024, '{8'd0,   8'd255, 8'd0  }, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{11'd1024, 11'd1024, '{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{11'd1024, 11'd1024, '{8'hAA,  8'h55,  8'h0F }, 1'b1, '{8'hAA,  8'h55,  8'h0F }},
    '{11'd1024, 11'd1024, '{8'h55,  8'hAA,  8'hF0 }, 1'b1, '{8'h55,  8'hAA,  8'hF0 }},
    '{11'd0,    11'd1024, '{8'd255, 8'd0,   8'd0  }, 1'b1, '{8'd29,  8'd29,  8'd29 }},
    '{11'd0,    11'd1024, '{8'd0,   8'd255, 8'd0  }, 1'b1, '{8'd149, 8'd149, 8'd149}},
    '{11'd0,    11'd1024, '{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd76,  8'd76,  8'd76 }},
    '{11'd0,    11'd1024, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{11'd0,    11'd1024, '{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1024, 11'd0,    '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1024, 11'd0,    '{8'hAA,  8'h55,  8'h0F }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{11'd2047, 11'd2047, '{8'h12,  8'h34,  8'h56 }, 1'b1, '{8'h12,  8'h34,  8'h56 }},
    '{11'd2047, 11'd2047, '{8'd255, 8'd128, 8'd1  }, 1'b1, '{8'd255, 8'd128, 8'd1  }},
    '{11'd1536, 11'd1025, '{8'd0,   8'd200, 8'd255}, 1'b1, '{8'd0,   8'd200, 8'd255}},
    '{11'd512,  11'd768,  '{8'd255, 8'd0,   8'd128}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{11'd512,  11'd768,  '{8'd17,  8'd200, 8'd90 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{11'd512,  11'd768,  '{8'd1,   8'd1,   8'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1023, 11'd1023, '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1023, 11'd1023, '{8'd0,   8'd255, 8'd0  }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
    '{11'd1,    11'd1,    '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }}
  };

  logic     clk;
  logic     rst;
  logic     wr_en;
  reg_idx_t wr_index;
  q10_t     wr_data;

  pdd_in_if  pix_in_ch ();
  pdd_out_if pix_out_ch ();

  pixel_desaturate_darken_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in_ch),
    .pix_out  (pix_out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // typed expectation travels with the request it belongs to
  logic   exp_known;
  pixel_t exp_typed;

  pixel_t pixels_due [$];
  q10_t   sat_now;
  q10_t   bri_now;
  int     n_errors;
  int     n_out;
  int     n_fixed;
  int     n_settings;
  int     n_long_holds;
  bit     tail_calm;
  bit     sender_idles;
  bit     hold_out_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic chan_t mix_chan(chan_t c, logic [63:0] luma, logic [63:0] s,
                                     logic [63:0] v);
    logic [63:0] blend;
    logic [63:0] scaled;
    blend  = luma * (64'(Q10_ONE) - s) + (64'(c) << 16) * s;
    scaled = (blend * v) >> FRAC_OUT;
    return (scaled > 64'(CHAN_MAX)) ? CHAN_MAX : scaled[7:0];
  endfunction

  function automatic pixel_t desat_darken(pixel_t p, q10_t sat_reg, q10_t bri_reg);
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] luma;
    pixel_t      res;
    s    = (sat_reg > Q10_ONE) ? 64'(Q10_ONE) : 64'(sat_reg);
    v    = (bri_reg > Q10_ONE) ? 64'(Q10_ONE) : 64'(bri_reg);
    luma = 64'(W_RED) * p.red + 64'(W_GREEN) * p.green + 64'(W_BLUE) * p.blue;
    res.blue  = mix_chan(p.blue, luma, s, v);
    res.green = mix_chan(p.green, luma, s, v);
    res.red   = mix_chan(p.red, luma, s, v);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_LINES) $display("tb: mismatch at result %0d: %s", n_out, msg);
  endtask

  task automatic check_chan(string name, chan_t got, chan_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Predict on accepted requests, check on accepted results.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      sat_now = Q10_ONE;
      bri_now = Q10_ONE;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SATURATION: sat_now = wr_data;
          REG_BRIGHTNESS: bri_now = wr_data;
          default: ;
        endcase
      end
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        if (exp_known) begin
          pixels_due.push_back(exp_typed);
          n_fixed++;
        end else begin
          pixels_due.push_back(desat_darken({pix_in_ch.blue_in, pix_in_ch.green_in,
                                             pix_in_ch.red_in}, sat_now, bri_now));
        end
      end
      if (pix_out_ch.valid && pix_out_ch.ready) begin
        got = {pix_out_ch.blue_out, pix_out_ch.green_out, pix_out_ch.red_out};
        if (pixels_due.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %0d/%0d/%0d",
                                    got.blue, got.green, got.red));
        end else begin
          want = pixels_due.pop_front();
          check_chan("blue", got.blue, want.blue);
          check_chan("green", got.green, want.green);
          check_chan("red", got.red, want.red);
        end
        n_out++;
      end
    end
  end

  // Output side: random stall bursts in stretches, one long hold on request.
  initial begin : out_side
    int mode_left;
    int stall_odds;
    pix_out_ch.ready <= 1'b0;
    mode_left = 0;
    stall_odds = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_odds = $urandom_range(0, 2);
        mode_left = 64;
      end
      mode_left--;
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        pix_out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        n_long_holds++;
        pix_out_ch.ready <= 1'b1;
      end else if (!tail_calm && stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
        pix_out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        pix_out_ch.ready <= 1'b1;
      end else begin
        pix_out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer_pixel(pixel_t p, logic known, pixel_t typed);
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.blue_in  <= p.blue;
    pix_in_ch.green_in <= p.green;
    pix_in_ch.red_in   <= p.red;
    exp_known          <= known;
    exp_typed          <= typed;
    do @(posedge clk); while (!pix_in_ch.ready);
  endtask

  task automatic maybe_pause();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      pix_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending pixel is back and the pipe is empty.
  task automatic settle();
    pix_in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_factors(q10_t sat, q10_t bri);
    wr_en    <= 1'b1;
    wr_index <= REG_SATURATION;
    wr_data  <= sat;
    @(posedge clk);
    wr_index <= REG_BRIGHTNESS;
    wr_data  <= bri;
    @(posedge clk);
    wr_en    <= 1'b0;
    n_settings++;
  endtask

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic q10_t pick_factor();
    if ($urandom_range(0, 3) == 0) return q10_t'($urandom_range(0, 2047));
    return q10_t'($urandom_range(0, 1024));
  endfunction

  initial begin : stimulus
    pixel_t px;
    q10_t   sat;
    q10_t   bri;
    int     cur_sat;
    int     cur_bri;
    n_errors = 0;
    n_out = 0;
    n_fixed = 0;
    n_settings = 0;
    n_long_holds = 0;
    tail_calm = 1'b0;
    hold_out_req = 1'b0;
    sender_idles = 1'b1;
    rst                <= 1'b1;
    pix_in_ch.valid    <= 1'b0;
    pix_in_ch.blue_in  <= '0;
    pix_in_ch.green_in <= '0;
    pix_in_ch.red_in   <= '0;
    exp_known          <= 1'b0;
    exp_typed          <= '0;
    wr_en              <= 1'b0;
    wr_index           <= REG_SATURATION;
    wr_data            <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_sat = -1;
    cur_bri = -1;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].sat != cur_sat || DIRECTED[i].bri != cur_bri) begin
        settle();
        set_factors(DIRECTED[i].sat, DIRECTED[i].bri);
        cur_sat = DIRECTED[i].sat;
        cur_bri = DIRECTED[i].bri;
      end
      offer_pixel(DIRECTED[i].px, DIRECTED[i].known, DIRECTED[i].typed);
      maybe_pause();
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin sat = 11'd0;    bri = 11'd1024; end
        1: begin sat = 11'd1024; bri = 11'd0;    end
        2: begin sat = 11'd2047; bri = 11'd2047; end
        3: begin sat = Q10_ONE;  bri = Q10_ONE;  end
        default: begin sat = pick_factor(); bri = pick_factor(); end
      endcase
      set_factors(sat, bri);
      tail_calm = (ph == N_PHASES - 1);
      // hold the output for a long stretch while requests keep coming
      if (ph == SQUEEZE_PHASE) hold_out_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 32 == 0)
          sender_idles = !tail_calm && ph != SQUEEZE_PHASE && $urandom_range(0, 2) != 0;
        px.blue  = pick_chan();
        px.green = pick_chan();
        px.red   = pick_chan();
        offer_pixel(px, 1'b0, '0);
        maybe_pause();
      end
    end
    settle();

    $display("tb: %0d pixels checked over %0d factor settings, %0d against fixed values,",
             n_out, n_settings, n_fixed);
    $display("tb: with %0d long output hold(s) of %0d cycles", n_long_holds, LONG_HOLD);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
sv/pdd_pkg.sv
sv/pdd_ifs.sv
sv/pixel_desaturate_darken_core.sv
sv/pdd_checker.sv
dv/testbench.sv
